FILE: sv/bounded_positional_list_unit_defines.svh
// ----------------------------------------------------------------------------
// Bounded positional list unit: assertion macros
// Shared property wrappers for the checker; clocked on the unit's clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_POSITIONAL_LIST_UNIT_DEFINES_SVH
`define BOUNDED_POSITIONAL_LIST_UNIT_DEFINES_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define BPL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bpl check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define BPL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bpl check failed");

`endif

FILE: sv/bpl_pkg.sv
// ----------------------------------------------------------------------------
// Bounded positional list package
// Operation, status and cell control codes, plus the cell control struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpl_pkg;

   localparam int VALUE_W  = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int MODE_W   = 3;

   // operations
   localparam logic [OP_W-1:0] OP_APPEND      = 3'd0;
   localparam logic [OP_W-1:0] OP_INSERT_HEAD = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE_LAST = 3'd2;
   localparam logic [OP_W-1:0] OP_DELETE_AT   = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT       = 3'd4;
   localparam logic [OP_W-1:0] OP_EMIT        = 3'd5;

   // result status
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd3;

   // cell update modes
   localparam logic [MODE_W-1:0] CELL_HOLD       = 3'd0;
   localparam logic [MODE_W-1:0] CELL_LOAD       = 3'd1;
   localparam logic [MODE_W-1:0] CELL_FROM_LEFT  = 3'd2;
   localparam logic [MODE_W-1:0] CELL_FROM_RIGHT = 3'd3;
   localparam logic [MODE_W-1:0] CELL_WRAP       = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [VALUE_W-1:0] load_value;
   } cell_ctl_type;

endpackage

FILE: sv/bpl_cell.sv
// ----------------------------------------------------------------------------
// Bounded positional list cell
// One list slot; loads a new value, takes a neighbor's value or the wrap
// value from the head cell, or holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpl_cell (
   input  logic                         clock,
   input  bpl_pkg::cell_ctl_type        ctl,
   input  logic [bpl_pkg::VALUE_W-1:0]  left_data,
   input  logic [bpl_pkg::VALUE_W-1:0]  right_data,
   input  logic [bpl_pkg::VALUE_W-1:0]  wrap_data,
   output logic [bpl_pkg::VALUE_W-1:0]  data
);

   logic [bpl_pkg::VALUE_W-1:0] data_ff;
   logic [bpl_pkg::VALUE_W-1:0] data_in;

   always_comb begin
      unique case (ctl.mode)
         bpl_pkg::CELL_LOAD:       data_in = ctl.load_value;
         bpl_pkg::CELL_FROM_LEFT:  data_in = left_data;
         bpl_pkg::CELL_FROM_RIGHT: data_in = right_data;
         bpl_pkg::CELL_WRAP:       data_in = wrap_data;
         default:                  data_in = data_ff;
      endcase
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

FILE: sv/bounded_positional_list_unit.sv
// ----------------------------------------------------------------------------
// Bounded positional list unit
// Ordered list of up to DEPTH signed 32-bit values kept in a chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat per operation. req_tuser = operation (3 bits).
//     req_tdata = position, then value, zero padded to whole bytes.
//   rsp channel: status in rsp_tuser, count and entry value in rsp_tdata,
//     rsp_tlast marks the final beat caused by a request.
//   Append, insert head, delete last, delete at, count and unknown codes
//     answer with one beat, registered: it shows in the cycle after the
//     request beat. With rsp_tready high these take one request per cycle,
//     since all cells shift in parallel.
//   Emit walks the list: it first enters the walk, then sends one beat per
//     entry, read from the head cell while the chain rotates left by one.
//     After count beats the chain is back in its original order. An emit
//     keeps req_tready low for the whole walk; an empty list answers one
//     beat with status empty.
//   A stalled rsp_tready holds the output register; the walk and new
//     requests wait for the register to free up. No beat is dropped.
//   Reset (synchronous, active high) empties the list and drops any pending
//     response. Cell contents are not cleared; only counted entries are read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounded_positional_list_unit #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // [OP_W-1:0] operation
   input  logic [bpl_pkg::OP_W-1:0]     req_tuser,
   // position [CW-1:0], value [CW+31:CW], zero pad above
   input  logic [((($clog2(DEPTH+1)) + bpl_pkg::VALUE_W + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [1:0] status
   output logic [bpl_pkg::STATUS_W-1:0] rsp_tuser,
   // count [CW-1:0], entry_value [CW+31:CW], zero pad above
   output logic [((($clog2(DEPTH+1)) + bpl_pkg::VALUE_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   output logic                         rsp_tlast
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int VW     = bpl_pkg::VALUE_W;
   localparam int DATA_W = ((CW + VW + 7) / 8) * 8;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EMIT = 1'b1;

   // control state
   logic          state_ff,    state_in;
   logic [CW-1:0] count_ff,    count_in;
   logic [CW-1:0] emit_idx_ff, emit_idx_in;

   // output register
   logic                         rsp_valid_ff,  rsp_valid_in;
   logic [bpl_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CW-1:0]                rsp_count_ff,  rsp_count_in;
   logic [VW-1:0]                rsp_value_ff,  rsp_value_in;
   logic                         rsp_last_ff,   rsp_last_in;

   // request fields
   logic [bpl_pkg::OP_W-1:0] op;
   logic [CW-1:0]            pos;
   logic [VW-1:0]            val;

   logic                         out_free;
   logic                         accept;
   logic                         emit_step;
   logic                         is_full;
   logic                         is_empty;
   logic [bpl_pkg::STATUS_W-1:0] status;
   logic                         op_ok;
   logic [CW-1:0]                last_idx;
   logic [CW-1:0]                pos_m1;

   // cell chain
   logic [VW-1:0]         cell_data [DEPTH];
   bpl_pkg::cell_ctl_type cell_ctl  [DEPTH];

   assign op  = req_tuser;
   assign pos = req_tdata[CW-1:0];
   assign val = req_tdata[CW+VW-1:CW];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign emit_step  = (state_ff == S_EMIT) && out_free;

   assign is_full  = (count_ff == CW'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign last_idx = count_ff - CW'(1);
   assign pos_m1   = pos - CW'(1);

   // status of the request on the input
   always_comb begin
      status = bpl_pkg::STAT_OK;
      case (op)
         bpl_pkg::OP_APPEND: begin
            if (is_full) status = bpl_pkg::STAT_FULL;
         end
         bpl_pkg::OP_INSERT_HEAD: begin
            if (pos != CW'(1))  status = bpl_pkg::STAT_BADPOS;
            else if (is_full)   status = bpl_pkg::STAT_FULL;
         end
         bpl_pkg::OP_DELETE_LAST: begin
            if (is_empty) status = bpl_pkg::STAT_EMPTY;
         end
         bpl_pkg::OP_DELETE_AT: begin
            if (is_empty)                             status = bpl_pkg::STAT_EMPTY;
            else if (pos == '0 || pos > count_ff)     status = bpl_pkg::STAT_BADPOS;
         end
         bpl_pkg::OP_EMIT: begin
            if (is_empty) status = bpl_pkg::STAT_EMPTY;
         end
         default: status = bpl_pkg::STAT_OK;
      endcase
   end

   assign op_ok = (status == bpl_pkg::STAT_OK);

   // count update
   always_comb begin
      count_in = count_ff;
      if (accept && op_ok) begin
         case (op)
            bpl_pkg::OP_APPEND,
            bpl_pkg::OP_INSERT_HEAD: count_in = count_ff + CW'(1);
            bpl_pkg::OP_DELETE_LAST,
            bpl_pkg::OP_DELETE_AT:   count_in = count_ff - CW'(1);
            default:                 count_in = count_ff;
         endcase
      end
   end

   // sequencer and output register
   always_comb begin
      state_in      = state_ff;
      emit_idx_in   = emit_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (op == bpl_pkg::OP_EMIT && !is_empty) begin
                  // walk starts next cycle from the head cell
                  state_in    = S_EMIT;
                  emit_idx_in = '0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = status;
                  rsp_count_in  = count_in;
                  rsp_value_in  = '0;
                  rsp_last_in   = 1'b1;
               end
            end
         end
         S_EMIT: begin
            if (emit_step) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = bpl_pkg::STAT_OK;
               rsp_count_in  = count_ff;
               rsp_value_in  = cell_data[0];
               rsp_last_in   = (emit_idx_ff == last_idx);
               emit_idx_in   = emit_idx_ff + CW'(1);
               if (emit_idx_ff == last_idx) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // chain of cells: cell 0 is the head
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [VW-1:0] left_data;
      logic [VW-1:0] right_data;

      if (i == 0) begin : g_head
         assign left_data = '0;
      end else begin : g_body
         assign left_data = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      always_comb begin
         cell_ctl[i].mode       = bpl_pkg::CELL_HOLD;
         cell_ctl[i].load_value = val;
         if (emit_step) begin
            // rotate the occupied part left by one
            if (CW'(i) == last_idx)     cell_ctl[i].mode = bpl_pkg::CELL_WRAP;
            else if (CW'(i) < last_idx) cell_ctl[i].mode = bpl_pkg::CELL_FROM_RIGHT;
         end else if (accept && op_ok) begin
            case (op)
               bpl_pkg::OP_APPEND: begin
                  if (CW'(i) == count_ff) cell_ctl[i].mode = bpl_pkg::CELL_LOAD;
               end
               bpl_pkg::OP_INSERT_HEAD: begin
                  if (i == 0)                  cell_ctl[i].mode = bpl_pkg::CELL_LOAD;
                  else if (CW'(i) <= count_ff) cell_ctl[i].mode = bpl_pkg::CELL_FROM_LEFT;
               end
               bpl_pkg::OP_DELETE_AT: begin
                  if (CW'(i) >= pos_m1) cell_ctl[i].mode = bpl_pkg::CELL_FROM_RIGHT;
               end
               default: cell_ctl[i].mode = bpl_pkg::CELL_HOLD;
            endcase
         end
      end

      bpl_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .left_data  (left_data),
         .right_data (right_data),
         .wrap_data  (cell_data[0]),
         .data       (cell_data[i])
      );
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = DATA_W'({rsp_value_ff, rsp_count_ff});
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: sv/bpl_checker.sv
// ----------------------------------------------------------------------------
// Bounded positional list checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bounded_positional_list_unit_defines.svh"

module bpl_checker #(
   parameter int DEPTH = 16
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [bpl_pkg::STATUS_W-1:0] rsp_tuser,
   input logic [((($clog2(DEPTH+1)) + bpl_pkg::VALUE_W + 7) / 8) * 8 - 1:0] rsp_tdata,
   input logic                         rsp_tlast
);

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] rsp_count;
   assign rsp_count = rsp_tdata[CW-1:0];

   // stalled beat holds
   `BPL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // full status only with a full list
   `BPL_ASSERT_NOW(a_full_count, clock, reset, rsp_tvalid && rsp_tuser == bpl_pkg::STAT_FULL, rsp_count == CW'(DEPTH))

   // empty status: nothing held, single final beat
   `BPL_ASSERT_NOW(a_empty_beat, clock, reset, rsp_tvalid && rsp_tuser == bpl_pkg::STAT_EMPTY, rsp_count == '0 && rsp_tlast)

   // only a walk has non-final beats, and those are all good
   `BPL_ASSERT_NOW(a_walk_ok, clock, reset, rsp_tvalid && !rsp_tlast, rsp_tuser == bpl_pkg::STAT_OK && rsp_count != '0)

endmodule

bind bounded_positional_list_unit bpl_checker #(.DEPTH(DEPTH)) u_bpl_checker (.*);

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Bounded positional list unit testbench
// Drives random and directed list operations into the req stream and checks
// every rsp beat against a local shadow of the list, with random gaps on
// both sides and one long response hold-off that backs up the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import bpl_pkg::*;

   localparam int DEPTH = 16;
   localparam int CW    = $clog2(DEPTH + 1);                 // count / position width
   localparam int DW    = ((CW + VALUE_W + 7) / 8) * 8;      // padded tdata width

   localparam int RANDOM_OPS     = 255;
   localparam int SETTLE_CYCLES  = 40;
   localparam int LONG_HOLD      = 150;   // cycles of rsp_tready low, once
   localparam int HOLD_AFTER     = 40;    // rsp beats seen before the long hold
   localparam int MAX_REPORTS    = 10;

   // op codes the unit does not define; they answer like a count
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [CW-1:0]             pos;
      logic signed [VALUE_W-1:0] val;
   } list_op_t;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic [CW-1:0]             count;
      logic signed [VALUE_W-1:0] val;
      logic                      last;
   } list_beat_t;

   // grow epochs push the list toward full, shrink epochs toward empty
   typedef enum logic [1:0] {MIX_GROW, MIX_SHRINK, MIX_ANY} op_mix_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [OP_W-1:0] req_tuser = '0;   // [2:0] operation
   logic [DW-1:0] req_tdata  = '0;    // position [CW-1:0], value [CW+31:CW], zero pad
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [STATUS_W-1:0] rsp_tuser;    // [1:0] status
   logic [DW-1:0] rsp_tdata;          // count [CW-1:0], entry value [CW+31:CW], zero pad
   logic          rsp_tlast;

   bounded_positional_list_unit #(
      .DEPTH (DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow list and the beats it predicts
   // ------------------------------------------------------------------------
   list_op_t   pending_ops[$];      // filled by the stimulus block, drained by the driver
   list_beat_t expected_beats[$];   // oldest first
   logic signed [VALUE_W-1:0] shadow_vals [DEPTH];
   int         shadow_count = 0;
   int         mismatches   = 0;

   // Apply one accepted op to the shadow list and queue the beats it causes.
   task automatic apply_list_op(input list_op_t cmd);
      logic [STATUS_W-1:0] st;
      int i;
      st = STAT_OK;
      case (cmd.op)
         OP_APPEND: begin
            if (shadow_count >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               shadow_vals[shadow_count] = cmd.val;
               shadow_count++;
            end
         end
         OP_INSERT_HEAD: begin
            // position is checked ahead of the full condition
            if (cmd.pos != CW'(1)) begin
               st = STAT_BADPOS;
            end else if (shadow_count >= DEPTH) begin
               st = STAT_FULL;
            end else begin
               for (i = shadow_count; i > 0; i--) shadow_vals[i] = shadow_vals[i-1];
               shadow_vals[0] = cmd.val;
               shadow_count++;
            end
         end
         OP_DELETE_LAST: begin
            if (shadow_count == 0) st = STAT_EMPTY;
            else shadow_count--;
         end
         OP_DELETE_AT: begin
            if (shadow_count == 0) begin
               st = STAT_EMPTY;
            end else if (cmd.pos == 0 || int'(cmd.pos) > shadow_count) begin
               st = STAT_BADPOS;
            end else begin
               for (i = int'(cmd.pos) - 1; i + 1 < shadow_count; i++)
                  shadow_vals[i] = shadow_vals[i+1];
               shadow_count--;
            end
         end
         OP_EMIT: begin
            // empty list still answers one beat, flagged empty
            if (shadow_count == 0) begin
               expected_beats.push_back('{STAT_EMPTY, CW'(0), 32'sd0, 1'b1});
            end else begin
               for (i = 0; i < shadow_count; i++)
                  expected_beats.push_back('{STAT_OK, CW'(shadow_count), shadow_vals[i],
                                             (i + 1 == shadow_count)});
            end
            return;
         end
         default: ;   // count and the spare codes change nothing
      endcase
      expected_beats.push_back('{st, CW'(shadow_count), 32'sd0, 1'b1});
   endtask

   // Gap length for either side: mostly none or short, a few long, and now
   // and then a calm stretch with no gaps at all.
   function automatic int draw_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // ------------------------------------------------------------------------
   // Request driver: presents one beat at a time from pending_ops. The op on
   // the bus goes into the shadow list on the edge where it is accepted.
   // ------------------------------------------------------------------------
   list_op_t on_bus;
   int       send_gap  = 0;
   int       send_calm = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) apply_list_op(on_bus);
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            on_bus = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= on_bus.op;
            req_tdata  <= DW'({on_bus.val, on_bus.pos});
            send_gap   = draw_gap(send_calm);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response side backpressure. After HOLD_AFTER beats it holds off once while
   // the driver keeps offering, so the unit's output register fills and
   // req_tready drops.
   // ------------------------------------------------------------------------
   int  recv_stall = 0;
   int  recv_calm  = 0;
   int  hold_left  = 0;
   int  recv_beats = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) recv_beats++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!long_hold_done && recv_beats >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            rsp_tready <= 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            recv_stall = draw_gap(recv_calm);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor: each accepted beat against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      list_beat_t want;
      list_beat_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tuser, rsp_tdata[CW-1:0], rsp_tdata[CW+VALUE_W-1:CW], rsp_tlast};
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: unexpected rsp beat status=%0d count=%0d value=%0d last=%0b",
                        $realtime, got.status, got.count, got.val, got.last);
         end else begin
            want = expected_beats.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"%0t: rsp mismatch exp status=%0d count=%0d value=%0d last=%0b",
                            " got status=%0d count=%0d value=%0d last=%0b"},
                           $realtime, want.status, want.count, want.val, want.last,
                           got.status, got.count, got.val, got.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_op(input logic [OP_W-1:0] op, input int pos, input int val);
      pending_ops.push_back('{op, CW'(pos), val});
   endtask

   initial begin
      op_mix_t mix;
      int      r;
      int      n;
      int      pos;
      int      val;
      logic [OP_W-1:0] op;

      mix = MIX_ANY;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-list corners first
      queue_op(OP_COUNT, 0, 0);
      queue_op(OP_DELETE_LAST, 0, 0);
      queue_op(OP_DELETE_AT, 1, 0);
      queue_op(OP_EMIT, 0, 0);
      // insert head: only position 1 is honored
      queue_op(OP_INSERT_HEAD, 1, 32'h8000_0000);
      queue_op(OP_APPEND, 31, 32'h7FFF_FFFF);
      queue_op(OP_INSERT_HEAD, 0, 5);
      queue_op(OP_INSERT_HEAD, 2, 6);
      queue_op(OP_INSERT_HEAD, 31, -1);
      queue_op(OP_APPEND, 0, 0);
      // delete at out of range: zero and past the count
      queue_op(OP_DELETE_AT, 0, 0);
      queue_op(OP_DELETE_AT, 4, 0);
      queue_op(OP_DELETE_AT, 16, 0);
      queue_op(OP_SPARE_LO, 0, 0);
      queue_op(OP_SPARE_HI, 31, -1);
      queue_op(OP_EMIT, 0, 0);
      queue_op(OP_DELETE_AT, 2, 0);
      queue_op(OP_EMIT, 0, 0);
      queue_op(OP_DELETE_LAST, 0, 0);
      queue_op(OP_DELETE_AT, 1, 0);   // single entry left
      queue_op(OP_COUNT, 0, 0);

      // random: epochs that push toward full or empty, so both ends are hit
      for (n = 0; n < RANDOM_OPS; n++) begin
         if (n % 30 == 0) mix = op_mix_t'($urandom_range(0, 2));
         r = $urandom_range(0, 99);
         case (mix)
            MIX_GROW:
               op = (r < 45) ? OP_APPEND : (r < 80) ? OP_INSERT_HEAD :
                    (r < 86) ? OP_EMIT : (r < 90) ? OP_COUNT :
                    (r < 95) ? OP_DELETE_AT : (r < 98) ? OP_DELETE_LAST :
                    OP_SPARE_LO;
            MIX_SHRINK:
               op = (r < 35) ? OP_DELETE_LAST : (r < 75) ? OP_DELETE_AT :
                    (r < 82) ? OP_EMIT : (r < 88) ? OP_COUNT :
                    (r < 94) ? OP_APPEND : (r < 97) ? OP_INSERT_HEAD :
                    OP_SPARE_HI;
            default:
               op = (r < 6) ? OP_SPARE_LO + OP_W'($urandom_range(0, 1)) :
                    OP_W'($urandom_range(0, 5));
         endcase

         // mostly well-formed positions, the rest anywhere in the field
         r = $urandom_range(0, 99);
         if (op == OP_INSERT_HEAD) pos = (r < 85) ? 1 : $urandom_range(0, 31);
         else if (op == OP_DELETE_AT) pos = (r < 75) ? $urandom_range(1, DEPTH)
                                                     : $urandom_range(0, 31);
         else pos = $urandom_range(0, 31);

         r = $urandom_range(0, 99);
         case (r % 10)
            0: val = (r < 50) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: val = (r < 50) ? 0 : -1;
            default: val = $urandom;
         endcase
         queue_op(op, pos, val);
      end

      // drain: everything sent, everything answered, then a quiet tail
      while (pending_ops.size() != 0 || req_tvalid) @(negedge clock);
      while (expected_beats.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog, well past the slowest legal run
   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: bounded_positional_list_unit.f
+incdir+sv
sv/bpl_pkg.sv
sv/bpl_cell.sv
sv/bounded_positional_list_unit.sv
sv/bpl_checker.sv
tb/sv/tb_top.sv
